// ----- design/assert_macros.svh -----
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/bdsb_pkg.sv -----
package bdsb_pkg;

    localparam int HIGH_COLS   = 128;
    localparam int LOW_COLS    = 64;
    localparam int SCROLL_STEP = 4;

    localparam int HIGH_ROWS = HIGH_COLS / 2;
    localparam int LOW_ROWS  = LOW_COLS / 2;
    localparam int WORD_W    = LOW_COLS;
    localparam int HI_ROW_WORDS = HIGH_COLS / WORD_W;
    localparam int HI_SH     = $clog2(HI_ROW_WORDS);
    localparam int DEPTH     = HIGH_ROWS * HI_ROW_WORDS;
    localparam int LOW_WORDS = LOW_ROWS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int IDX_W     = 13;
    localparam int AMT_W     = 4;
    localparam int CMD_W     = 3;
    localparam int LOW_AREA  = LOW_COLS * LOW_ROWS;
    localparam int HIGH_AREA = HIGH_COLS * HIGH_ROWS;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_PIXEL    = 3'd0,
        CMD_SET_MODE     = 3'd1,
        CMD_SCROLL_LEFT  = 3'd2,
        CMD_SCROLL_RIGHT = 3'd3,
        CMD_SCROLL_DOWN  = 3'd4,
        CMD_CLEAR        = 3'd5,
        CMD_READ_PIXEL   = 3'd6
    } cmd_t;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic rd_sweep;
        logic wb_en;
        logic sweep_start;
        logic sweep_step;
        logic set_mode;
        logic clear_all;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic mode_change;
        logic sweep_last;
        logic out_free;
    } ctrl_stat_t;

endpackage

// ----- design/bdsb_ctrl.sv -----
module bdsb_ctrl
    import bdsb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SWEEP,
        S_FLUSH,
        S_FETCH,
        S_CAPTURE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.cmd)
                    CMD_SET_PIXEL:
                    begin
                        ctrl.rd_en = 1'b1;
                        ctrl.wb_en = 1'b1;
                        state_next = S_FLUSH;
                    end
                    CMD_SET_MODE:
                    begin
                        if (stat.mode_change)
                        begin
                            ctrl.set_mode  = 1'b1;
                            ctrl.clear_all = 1'b1;
                        end
                        state_next = S_FETCH;
                    end
                    CMD_SCROLL_LEFT, CMD_SCROLL_RIGHT, CMD_SCROLL_DOWN:
                    begin
                        ctrl.sweep_start = 1'b1;
                        state_next       = S_SWEEP;
                    end
                    CMD_CLEAR:
                    begin
                        ctrl.clear_all = 1'b1;
                        state_next     = S_FETCH;
                    end
                    default:
                    begin
                        state_next = S_FETCH;
                    end
                endcase
            end
            S_SWEEP:
            begin
                ctrl.rd_en      = 1'b1;
                ctrl.rd_sweep   = 1'b1;
                ctrl.wb_en      = 1'b1;
                ctrl.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                ctrl.rd_en = 1'b1;
                state_next = S_CAPTURE;
            end
            S_CAPTURE:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/bdsb_datapath.sv -----
module bdsb_datapath
    import bdsb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CMD_W-1:0] cmd,
    input  logic [IDX_W-1:0] pixel_index,
    input  logic             pixel_value,
    input  logic             hires_enable,
    input  logic [AMT_W-1:0] scroll_amount,
    input  ctrl_cmd_t        ctrl,
    output ctrl_stat_t       stat,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             read_pixel,
    output logic             hires_active
);

    cmd_t             cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             val_reg;
    logic             hi_reg;
    logic [AMT_W-1:0] amt_reg;
    logic             hires_reg;

    addr_t            cnt_reg;
    word_t            mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    word_t            rdata_reg;
    logic             rvld_reg;
    logic             wb_reg;
    addr_t            waddr_reg;
    logic             zero_reg;
    word_t            prev_reg;

    logic             out_valid_reg;
    logic             read_pixel_reg;
    logic             hires_active_reg;

    addr_t            idx_addr;
    addr_t            last_addr;
    addr_t            down_dist;
    addr_t            src_addr;
    addr_t            raddr;
    logic             descending;
    logic             down_zero;
    logic             in_range;
    logic [IDX_W:0]   idx_ext;
    word_t            old_word;
    word_t            wdata;
    logic             wr_en;
    logic             carry_left;
    logic             carry_right;

    // item capture
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd_t'(cmd);
            idx_reg <= pixel_index;
            val_reg <= pixel_value;
            hi_reg  <= hires_enable;
            amt_reg <= scroll_amount;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hires_reg <= 1'b0;
        end
        else if (ctrl.set_mode)
        begin
            hires_reg <= hi_reg;
        end
    end

    // address generation
    assign idx_addr   = idx_reg[IDX_W-1:BIT_W];
    assign last_addr  = hires_reg ? addr_t'(DEPTH - 1) : addr_t'(LOW_WORDS - 1);
    assign descending = (cmd_reg != CMD_SCROLL_RIGHT);
    assign down_dist  = hires_reg ? addr_t'({amt_reg, {HI_SH{1'b0}}}) : addr_t'(amt_reg);
    assign down_zero  = (cnt_reg < down_dist);
    assign src_addr   = cnt_reg - down_dist;

    always_comb
    begin
        if (!ctrl.rd_sweep)
        begin
            raddr = idx_addr;
        end
        else if (cmd_reg == CMD_SCROLL_DOWN)
        begin
            raddr = src_addr;
        end
        else
        begin
            raddr = cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sweep_start)
        begin
            cnt_reg <= descending ? last_addr : '0;
        end
        else if (ctrl.sweep_step)
        begin
            cnt_reg <= descending ? cnt_reg - addr_t'(1) : cnt_reg + addr_t'(1);
        end
    end

    // row word read
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[raddr];
            rvld_reg  <= vld_reg[raddr];
            waddr_reg <= ctrl.rd_sweep ? cnt_reg : idx_addr;
            zero_reg  <= down_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg <= 1'b0;
        end
        else
        begin
            wb_reg <= ctrl.rd_en & ctrl.wb_en;
        end
    end

    assign old_word = rvld_reg ? rdata_reg : '0;

    always_ff @(posedge clk)
    begin
        if (wb_reg)
        begin
            prev_reg <= old_word;
        end
    end

    // neighbor word in the same row carries bits across the word boundary
    assign carry_left  = hires_reg & ~waddr_reg[0];
    assign carry_right = hires_reg & waddr_reg[0];

    assign idx_ext  = {1'b0, idx_reg};
    assign in_range = hires_reg ? (idx_ext < (IDX_W + 1)'(HIGH_AREA))
                                : (idx_ext < (IDX_W + 1)'(LOW_AREA));

    always_comb
    begin
        wdata = old_word;
        case (cmd_reg)
            CMD_SET_PIXEL:
            begin
                wdata[idx_reg[BIT_W-1:0]] = val_reg;
            end
            CMD_SCROLL_LEFT:
            begin
                wdata = old_word >> SCROLL_STEP;
                if (carry_left)
                begin
                    wdata = wdata | {prev_reg[SCROLL_STEP-1:0],
                                     {(WORD_W - SCROLL_STEP){1'b0}}};
                end
            end
            CMD_SCROLL_RIGHT:
            begin
                wdata = old_word << SCROLL_STEP;
                if (carry_right)
                begin
                    wdata = wdata | word_t'(prev_reg[WORD_W-1 -: SCROLL_STEP]);
                end
            end
            CMD_SCROLL_DOWN:
            begin
                wdata = zero_reg ? '0 : old_word;
            end
            default:
            begin
                wdata = old_word;
            end
        endcase
    end

    assign wr_en = wb_reg & ((cmd_reg != CMD_SET_PIXEL) | in_range);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr_reg] <= wdata;
        end
    end

    // per-word valid bits, a cleared word reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctrl.clear_all)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[waddr_reg] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            read_pixel_reg   <= in_range & old_word[idx_reg[BIT_W-1:0]];
            hires_active_reg <= hires_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_pixel   = read_pixel_reg;
    assign hires_active = hires_active_reg;

    assign stat.cmd         = cmd_reg;
    assign stat.mode_change = (hi_reg != hires_reg);
    assign stat.sweep_last  = descending ? (cnt_reg == '0) : (cnt_reg == last_addr);
    assign stat.out_free    = ~out_valid_reg | out_ready;

endmodule

// ----- design/bitmap_display_scroll_buffer.sv -----
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// input    | in_valid / in_ready  | cmd, pixel_index, pixel_value,
//          |                      | hires_enable, scroll_amount
// output   | out_valid / out_ready| read_pixel, hires_active
//
// one command at a time; set pixel goes through dispatch, flush, fetch and capture,
// mode, clear, read and unused codes through dispatch, fetch and capture
// scrolls walk the active rows one 64-bit word per cycle through the single
// memory port pair: all 32 words in low resolution, all 128 in high resolution
// reset clears all word valid bits at once, so the screen reads dark at once
// a new command is taken while the previous result waits on out_ready
module bitmap_display_scroll_buffer
    import bdsb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CMD_W-1:0] cmd,
    input  logic [IDX_W-1:0] pixel_index,
    input  logic             pixel_value,
    input  logic             hires_enable,
    input  logic [AMT_W-1:0] scroll_amount,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             read_pixel,
    output logic             hires_active
);

    ctrl_cmd_t  ctrl;
    ctrl_stat_t stat;

    bdsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    bdsb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .pixel_index   (pixel_index),
        .pixel_value   (pixel_value),
        .hires_enable  (hires_enable),
        .scroll_amount (scroll_amount),
        .ctrl          (ctrl),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_pixel    (read_pixel),
        .hires_active  (hires_active)
    );

endmodule

// ----- design/bdsb_checker.sv -----
`include "assert_macros.svh"

module bdsb_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic read_pixel,
    input logic hires_active
);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_pixel) && $stable(hires_active))

    // one command in flight
    `ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)

    // no result in the cycle right after an input transfer
    `ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))

    // a result only appears while a command is being worked on
    `ASSERT_IMPLIES(a_result_from_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind bitmap_display_scroll_buffer bdsb_checker u_bdsb_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import bdsb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [CMD_W-1:0] op;
        logic [IDX_W-1:0] idx;
        logic             val;
        logic             hi;
        logic [AMT_W-1:0] amt;
        int               gap;
        bit               drain;
    } display_cmd_t;

    typedef struct {
        logic read_pixel;
        logic hires_active;
    } pixel_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [CMD_W-1:0] cmd = CMD_READ_PIXEL;
    logic [IDX_W-1:0] pixel_index = '0;
    logic             pixel_value = 1'b0;
    logic             hires_enable = 1'b0;
    logic [AMT_W-1:0] scroll_amount = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             read_pixel;
    logic             hires_active;

    display_cmd_t  pending_cmds[$];
    pixel_result_t expected_reads[$];
    display_cmd_t  next_cmd;
    pixel_result_t want;

    bit [HIGH_AREA-1:0] frame_bits = '0;
    bit                 model_hires = 1'b0;

    bit  src_busy = 1'b1;
    bit  sink_busy = 1'b1;
    int  src_wait = 0;
    int  sink_wait = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  gen_hires = 1'b0;

    bitmap_display_scroll_buffer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .pixel_index   (pixel_index),
        .pixel_value   (pixel_value),
        .hires_enable  (hires_enable),
        .scroll_amount (scroll_amount),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_pixel    (read_pixel),
        .hires_active  (hires_active)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // applies one command to the screen copy and returns the pixel and mode seen after it
    function automatic pixel_result_t predict_display(logic [CMD_W-1:0] op,
                                                      logic [IDX_W-1:0] idx,
                                                      logic val, logic hi,
                                                      logic [AMT_W-1:0] amt);
        int cols;
        int rows;
        int shift;
        pixel_result_t res;
        cols = model_hires ? HIGH_COLS : LOW_COLS;
        rows = cols / 2;
        shift = int'(amt);
        case (op)
            CMD_SET_PIXEL:
            begin
                if (int'(idx) < cols * rows)
                    frame_bits[idx] = val;
            end
            CMD_SET_MODE:
            begin
                if (hi != model_hires)
                begin
                    model_hires = hi;
                    frame_bits = '0;
                end
            end
            CMD_SCROLL_LEFT:
            begin
                for (int r = 0; r < rows; r++)
                    for (int c = 0; c < cols; c++)
                        if (c + SCROLL_STEP < cols)
                            frame_bits[r * cols + c] = frame_bits[r * cols + c + SCROLL_STEP];
                        else
                            frame_bits[r * cols + c] = 1'b0;
            end
            CMD_SCROLL_RIGHT:
            begin
                for (int r = 0; r < rows; r++)
                    for (int c = cols - 1; c >= 0; c--)
                        if (c >= SCROLL_STEP)
                            frame_bits[r * cols + c] = frame_bits[r * cols + c - SCROLL_STEP];
                        else
                            frame_bits[r * cols + c] = 1'b0;
            end
            CMD_SCROLL_DOWN:
            begin
                for (int r = rows - 1; r >= 0; r--)
                    for (int c = 0; c < cols; c++)
                        if (r >= shift)
                            frame_bits[r * cols + c] = frame_bits[(r - shift) * cols + c];
                        else
                            frame_bits[r * cols + c] = 1'b0;
            end
            CMD_CLEAR:
            begin
                frame_bits = '0;
            end
            default:
            begin
            end
        endcase
        cols = model_hires ? HIGH_COLS : LOW_COLS;
        res.read_pixel = (int'(idx) < cols * (cols / 2)) ? frame_bits[idx] : 1'b0;
        res.hires_active = model_hires;
        return res;
    endfunction

    function automatic display_cmd_t make_cmd(logic [CMD_W-1:0] op, int idx, logic val,
                                              logic hi, int amt, bit drain);
        display_cmd_t item;
        item.op = op;
        item.idx = idx[IDX_W-1:0];
        item.val = val;
        item.hi = hi;
        item.amt = amt[AMT_W-1:0];
        item.gap = src_busy ? $urandom_range(0, 9) : 0;
        item.drain = drain;
        return item;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            src_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_reads.push_back(predict_display(cmd, pixel_index, pixel_value,
                                                         hires_enable, scroll_amount));
            if (!in_valid || in_ready)
            begin
                if (pending_cmds.size() == 0)
                    in_valid <= 1'b0;
                else if (src_wait < pending_cmds[0].gap ||
                         (pending_cmds[0].drain && expected_reads.size() != 0))
                begin
                    in_valid <= 1'b0;
                    if (src_wait < pending_cmds[0].gap)
                        src_wait++;
                end
                else
                begin
                    next_cmd = pending_cmds.pop_front();
                    cmd <= next_cmd.op;
                    pixel_index <= next_cmd.idx;
                    pixel_value <= next_cmd.val;
                    hires_enable <= next_cmd.hi;
                    scroll_amount <= next_cmd.amt;
                    in_valid <= 1'b1;
                    src_wait = 0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reads.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reads.pop_front();
                    if (read_pixel !== want.read_pixel)
                    begin
                        $error("read_pixel expected %0d actual %0d", want.read_pixel, read_pixel);
                        mismatch_count++;
                    end
                    if (hires_active !== want.hires_active)
                    begin
                        $error("hires_active expected %0d actual %0d",
                               want.hires_active, hires_active);
                        mismatch_count++;
                    end
                end
                results_seen++;
                if (results_seen % 64 == 0)
                    sink_busy = ($urandom_range(0, 2) != 0);
                sink_wait = sink_busy ? $urandom_range(0, 9) : 0;
            end
            if (sink_wait > 0)
            begin
                out_ready <= 1'b0;
                sink_wait--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL bitmap_display_scroll_buffer");
            $finish;
        end
    end

    initial
    begin
        int pick;
        int lim;
        int idx;
        logic [CMD_W-1:0] op;

        // directed: reset state, area edges, every command, mode rules
        pending_cmds.push_back(make_cmd(CMD_READ_PIXEL, 0, 1'b1, 1'b1, 15, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_READ_PIXEL, 8191, 1'b0, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SET_PIXEL, 0, 1'b1, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SET_PIXEL, 2047, 1'b1, 1'b1, 15, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SET_PIXEL, 2048, 1'b1, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_READ_PIXEL, 2048, 1'b0, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SET_PIXEL, 63, 1'b1, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SET_PIXEL, 64, 1'b1, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SCROLL_LEFT, 59, 1'b0, 1'b1, 15, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_READ_PIXEL, 2043, 1'b0, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SCROLL_RIGHT, 63, 1'b0, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SCROLL_RIGHT, 3, 1'b0, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SCROLL_DOWN, 67, 1'b0, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SCROLL_DOWN, 131, 1'b0, 1'b0, 1, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SCROLL_DOWN, 1091, 1'b0, 1'b0, 15, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SET_MODE, 1091, 1'b0, 1'b0, 0, 1'b1));
        pending_cmds.push_back(make_cmd(CMD_UNUSED, 1091, 1'b1, 1'b1, 7, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SET_MODE, 1091, 1'b0, 1'b1, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SET_PIXEL, 8191, 1'b1, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SET_PIXEL, 8190, 1'b1, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SCROLL_LEFT, 8187, 1'b0, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SCROLL_DOWN, 8187, 1'b0, 1'b0, 15, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SET_PIXEL, 8187, 1'b0, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 1'b0, 1'b0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_SET_MODE, 0, 1'b0, 1'b0, 0, 1'b0));

        // random: pixel writes are the most common command, mostly in the active area so scrolls move real content
        for (int n = 0; n < 1000; n++)
        begin
            if (n % 50 == 0)
                src_busy = ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = CMD_SET_PIXEL;
            else if (pick < 70)
                op = CMD_READ_PIXEL;
            else if (pick < 75)
                op = CMD_SCROLL_LEFT;
            else if (pick < 80)
                op = CMD_SCROLL_RIGHT;
            else if (pick < 91)
                op = CMD_SCROLL_DOWN;
            else if (pick < 95)
                op = CMD_SET_MODE;
            else if (pick < 97)
                op = CMD_CLEAR;
            else
                op = CMD_UNUSED;
            lim = gen_hires ? HIGH_AREA - 1 : LOW_AREA - 1;
            pick = $urandom_range(0, 9);
            if (pick < 8)
                idx = $urandom_range(0, lim);
            else if (pick < 9)
                idx = $urandom_range(0, 8191);
            else
                idx = ($urandom_range(0, 1) != 0) ? lim : 8191;
            pending_cmds.push_back(make_cmd(op, idx, 1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)), $urandom_range(0, 15),
                                            (n % 200 == 199)));
            if (op == CMD_SET_MODE)
                gen_hires = pending_cmds[pending_cmds.size() - 1].hi;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_reads.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_reads.size() == 0)
            $display("PASS bitmap_display_scroll_buffer");
        else
            $display("FAIL bitmap_display_scroll_buffer");
        $finish;
    end

endmodule
